FILE: hw/rtl/assert_macros.svh
// Assertion macros for the list engine RTL; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define OLA_ASSERT_IMP(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define OLA_ASSERT_NXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define OLA_ASSERT_IMP(label, clock, rstn, ante, cons)

`define OLA_ASSERT_NXT(label, clock, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/ola_pkg.sv
// Types, codes and constants of the ordered array list engine.
package ola_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 5;
    localparam int VAL_W        = 32;
    localparam int STATUS_W     = 3;
    localparam int FOUND_W      = 4;
    localparam int COUNT_W      = 5;
    localparam int SCAN_GRP     = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_INSERT     = 3'd4,
        KIND_ERASE      = 3'd5,
        KIND_FIND       = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_POS   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_CLOSE = 2'd2,
        CELL_MATCH = 2'd3
    } cell_op_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        cell_op_t          op;
        logic [VAL_W-1:0]  value;
    } cell_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_res_t;

endpackage

FILE: hw/rtl/ordered_array_list_engine.sv
// Ordered array list engine: request channel, result channel, cell row and control.
// Usage:
//   Requests arrive on req_valid/req_stall with kind, position and value; one
//   result beat per request leaves on rsp_valid/rsp_stall with status,
//   found_index and count. A beat moves when valid is high and stall is low.
//   Every list operation but find completes at the accepting edge: its
//   result is valid in the next cycle, one request per cycle unless stalled.
//   Find latches a match flag in every cell at the accepting edge, then the
//   search unit walks the flags eight cells per cycle; the result is
//   registered once it reaches the group holding the first match, or the
//   last of up to ceil(CAPACITY/8) groups, and no request is taken meanwhile.
//   The result register is one beat deep: while a result waits under a
//   stalled receiver, every new request is held off.
//   Reset empties the list at once (count zero, no clearing sweep); entry
//   contents above the count are never read.
//   Failing requests leave the list untouched and report full, empty, bad
//   position or not found; kind 7 is a no-op reporting ok.
module ordered_array_list_engine
    import ola_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [POS_W-1:0]    position,
    input  logic [VAL_W-1:0]    value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [FOUND_W-1:0]  found_index,
    output logic [COUNT_W-1:0]  count
);

`include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (POS_W > CW) ? POS_W : CW;
    localparam int IW = $clog2(CAPACITY);

    state_t               state_reg;
    state_t               state_next;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic [FOUND_W-1:0]   found_reg;
    logic [FOUND_W-1:0]   found_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 load;
    logic                 accept;
    logic                 out_free;
    logic                 start;
    logic                 full;
    logic                 empty;
    logic [PW-1:0]        pos_ext;
    logic [PW-1:0]        cnt_ext;
    logic [PW-1:0]        at;
    cell_cmd_t            cmd;
    scan_res_t            scan_res;
    logic [IW-1:0]        scan_idx;
    logic [VAL_W-1:0]     entry_w [CAPACITY];
    logic [CAPACITY-1:0]  match_w;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = req_valid && !req_stall;
    assign full      = (cnt_reg == CW'(CAPACITY));
    assign empty     = (cnt_reg == '0);
    assign pos_ext   = PW'(position);
    assign cnt_ext   = PW'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd.op         = CELL_HOLD;
        cmd.value      = value;
        at             = '0;
        start          = 1'b0;
        load           = 1'b0;
        status_next    = STAT_OK;
        found_next     = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (kind_t'(kind))
                        KIND_PUSH_BACK, KIND_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op   = CELL_OPEN;
                                at       = (kind_t'(kind) == KIND_PUSH_BACK) ? cnt_ext : '0;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.op   = CELL_CLOSE;
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                status_next = STAT_BAD_POS;
                            end
                            else if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op   = CELL_OPEN;
                                at       = pos_ext;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        KIND_ERASE:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (pos_ext >= cnt_ext)
                            begin
                                status_next = STAT_BAD_POS;
                            end
                            else
                            begin
                                cmd.op   = CELL_CLOSE;
                                at       = pos_ext;
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        KIND_FIND:
                        begin
                            load       = 1'b0;
                            cmd.op     = CELL_MATCH;
                            start      = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done && out_free)
                begin
                    load        = 1'b1;
                    status_next = scan_res.hit ? STAT_OK : STAT_NOT_FOUND;
                    found_next  = scan_res.hit ? FOUND_W'(scan_idx) : '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        count_next = COUNT_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            count_reg  <= count_next;
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [VAL_W-1:0] lower_w;
            logic [VAL_W-1:0] upper_w;
            if (i == 0)
            begin : g_first
                assign lower_w = value;
            end
            else
            begin : g_mid_lo
                assign lower_w = entry_w[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign upper_w = entry_w[i];
            end
            else
            begin : g_mid_hi
                assign upper_w = entry_w[i+1];
            end
            ola_cell #(
                .INDEX (i),
                .PW    (PW),
                .CW    (CW)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .at    (at),
                .cnt   (cnt_reg),
                .lower (lower_w),
                .upper (upper_w),
                .entry (entry_w[i]),
                .match (match_w[i])
            );
        end
    endgenerate

    ola_scan #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .take  (out_free),
        .match (match_w),
        .res   (scan_res),
        .index (scan_idx)
    );

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign count       = count_reg;

    `OLA_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= CW'(CAPACITY))
    `OLA_ASSERT_IMP(a_scan_holds_req, clk, rst_n, state_reg == ST_SCAN, req_stall)
    `OLA_ASSERT_NXT(a_find_scans, clk, rst_n, accept && kind_t'(kind) == KIND_FIND, state_reg == ST_SCAN)
    `OLA_ASSERT_NXT(a_op_result, clk, rst_n, accept && kind_t'(kind) != KIND_FIND, rsp_valid)

endmodule

FILE: hw/rtl/ola_cell.sv
// One list cell: holds an entry, shifts with its neighbours and flags a match.
module ola_cell
    import ola_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int PW    = POS_W,
    parameter int CW    = COUNT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [PW-1:0]    at,
    input  logic [CW-1:0]    cnt,
    input  logic [VAL_W-1:0] lower,
    input  logic [VAL_W-1:0] upper,
    output logic [VAL_W-1:0] entry,
    output logic             match
);

    localparam logic [PW-1:0] IDX_P = PW'(INDEX);
    localparam logic [CW-1:0] IDX_C = CW'(INDEX);

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic             match_reg;
    logic             match_next;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (cmd.op)
            CELL_OPEN:
            begin
                if (IDX_P > at)
                begin
                    entry_next = lower;
                end
                else if (IDX_P == at)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_CLOSE:
            begin
                if (IDX_P >= at)
                begin
                    entry_next = upper;
                end
            end
            CELL_MATCH:
            begin
                match_next = (IDX_C < cnt) && (entry_reg == cmd.value);
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

FILE: hw/rtl/ola_scan.sv
// First-match search over the cell match flags, one group of cells per cycle.
module ola_scan
    import ola_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IW       = $clog2(CAPACITY)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                take,
    input  logic [CAPACITY-1:0] match,
    output scan_res_t           res,
    output logic [IW-1:0]       index
);

    localparam int GRP  = (CAPACITY < SCAN_GRP) ? CAPACITY : SCAN_GRP;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
    localparam int PADW = NGRP * GRP;
    localparam int XW   = $clog2(PADW);
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int KW   = (GRP > 1) ? $clog2(GRP) : 1;

    logic            active_reg;
    logic [GW-1:0]   grp_reg;
    logic [PADW-1:0] padded;
    logic [XW-1:0]   base;
    logic [GRP-1:0]  slice;
    logic [KW-1:0]   kpos;
    logic [XW-1:0]   index_full;
    logic            hit;
    logic            last;

    always_comb
    begin
        padded = PADW'(match);
        base   = XW'(grp_reg) * XW'(GRP);
        slice  = padded[base +: GRP];
        hit    = |slice;
        kpos   = '0;
        for (int k = GRP - 1; k >= 0; k--)
        begin
            if (slice[k])
            begin
                kpos = KW'(k);
            end
        end
        index_full = base + XW'(kpos);
        last       = (grp_reg == GW'(NGRP - 1));
    end

    assign index    = IW'(index_full);
    assign res.done = active_reg && (hit || last);
    assign res.hit  = active_reg && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            grp_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            grp_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (hit || last)
            begin
                if (take)
                begin
                    active_reg <= 1'b0;
                end
            end
            else
            begin
                grp_reg <= grp_reg + GW'(1);
            end
        end
    end

endmodule
